@@ hw/rtl/u8r_pkg.sv @@
// types shared by the utf-8 repair block: channel payloads and the job
// descriptor handed from the front classifier to the back serializer
// no dependencies
`timescale 1ns / 1ps

package u8r_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
  } out_item_t;

  // one accepted item that produces output: held bytes first, then the new byte
  typedef struct packed {
    logic [2:0][7:0] pend;      // held sequence bytes, oldest at index 0
    logic [1:0]      pend_cnt;  // how many held bytes are emitted
    logic            pend_lat;  // held bytes re-encoded as latin-1
    logic [7:0]      cur_byte;
    logic            cur_en;    // new byte is emitted after the held ones
    logic            cur_lat;
    logic            last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ hw/rtl/u8r_front.sv @@
// front side: accepts input items, tracks the open utf-8 sequence and
// builds one job per item that produces output
// depends on u8r_pkg
`timescale 1ns / 1ps

module u8r_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  u8r_pkg::in_item_t in_data,
  input  u8r_pkg::q_stat_t  q_stat,
  output logic              q_push,
  output u8r_pkg::job_t     q_job
);

  logic            repair_en_r;
  logic            in_seq_r, in_seq_nxt;
  logic [1:0]      need_r, need_nxt;
  logic [1:0]      pcnt_r, pcnt_nxt;
  logic [2:0][7:0] pend_r, pend_nxt;

  logic       accept;
  logic       has_out;
  logic [7:0] b;
  logic       last;
  logic       is_cont;
  logic       is_lead;
  logic [1:0] lead_need;
  logic [1:0] need_dec;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign q_push   = accept && has_out;

  always_comb begin
    b         = in_data.in_byte;
    last      = in_data.end_of_string;
    is_cont   = (b[7:6] == 2'b10);
    is_lead   = (b[7:6] == 2'b11);
    lead_need = !b[5] ? 2'd1 : (!b[4] ? 2'd2 : 2'd3);
    need_dec  = (need_r == 2'd0) ? 2'd0 : need_r - 2'd1;

    q_job.pend     = pend_r;
    q_job.pend_cnt = 2'd0;
    q_job.pend_lat = 1'b1;
    q_job.cur_byte = b;
    q_job.cur_en   = 1'b1;
    q_job.cur_lat  = 1'b1;
    q_job.last     = last;
    has_out        = 1'b0;

    in_seq_nxt = in_seq_r;
    need_nxt   = need_r;
    pcnt_nxt   = pcnt_r;
    pend_nxt   = pend_r;

    if (!repair_en_r) begin
      q_job.pend_cnt = pcnt_r;
      q_job.pend_lat = 1'b0;
      q_job.cur_lat  = 1'b0;
      has_out        = 1'b1;
      in_seq_nxt     = 1'b0;
      need_nxt       = 2'd0;
      pcnt_nxt       = 2'd0;
    end else if (!in_seq_r) begin
      if (is_lead && !last) begin
        in_seq_nxt  = 1'b1;
        need_nxt    = lead_need;
        pcnt_nxt    = 2'd1;
        pend_nxt[0] = b;
      end else begin
        // ascii, stray continuation, or a lead flushed at end of string
        has_out = 1'b1;
      end
    end else if (is_cont) begin
      if (need_dec == 2'd0 || pcnt_r == 2'd3) begin
        // sequence complete, passes unchanged
        q_job.pend_cnt = pcnt_r;
        q_job.pend_lat = 1'b0;
        q_job.cur_lat  = 1'b0;
        has_out        = 1'b1;
        in_seq_nxt     = 1'b0;
        need_nxt       = 2'd0;
        pcnt_nxt       = 2'd0;
      end else if (last) begin
        q_job.pend_cnt = pcnt_r;
        has_out        = 1'b1;
        in_seq_nxt     = 1'b0;
        need_nxt       = 2'd0;
        pcnt_nxt       = 2'd0;
      end else begin
        pend_nxt[pcnt_r] = b;
        pcnt_nxt         = pcnt_r + 2'd1;
        need_nxt         = need_dec;
      end
    end else begin
      // broken sequence: held bytes go out as latin-1, new byte handled afresh
      q_job.pend_cnt = pcnt_r;
      has_out        = 1'b1;
      if (is_lead && !last) begin
        q_job.cur_en = 1'b0;
        in_seq_nxt   = 1'b1;
        need_nxt     = lead_need;
        pcnt_nxt     = 2'd1;
        pend_nxt[0]  = b;
      end else begin
        in_seq_nxt = 1'b0;
        need_nxt   = 2'd0;
        pcnt_nxt   = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repair_en_r <= 1'b1;
      in_seq_r    <= 1'b0;
      need_r      <= 2'd0;
      pcnt_r      <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        repair_en_r <= cfg_wr_data;
      end
      if (accept) begin
        in_seq_r <= in_seq_nxt;
        need_r   <= need_nxt;
        pcnt_r   <= pcnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_r <= pend_nxt;
    end
  end

endmodule

@@ hw/rtl/u8r_queue.sv @@
// short job queue between the front classifier and the back serializer
// depends on u8r_pkg
`timescale 1ns / 1ps

module u8r_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  u8r_pkg::job_t    push_job,
  input  logic             pop,
  output u8r_pkg::job_t    head_job,
  output u8r_pkg::q_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  u8r_pkg::job_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign head_job   = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == FULL_CNT);
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_ONE;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_ONE;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_ONE;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ hw/rtl/u8r_back.sv @@
// back side: walks the head job one output byte per cycle unless stalled,
// expanding latin-1 bytes into two-byte utf-8, into the output register
// depends on u8r_pkg
`timescale 1ns / 1ps

module u8r_back (
  input  logic               clk,
  input  logic               rst_n,
  input  u8r_pkg::job_t      job,
  input  u8r_pkg::q_stat_t   q_stat,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output u8r_pkg::out_item_t out_data
);

  logic [1:0] pos_r;
  logic       half_r;
  logic       out_valid_r;
  u8r_pkg::out_item_t out_data_r;

  logic       load;
  logic       at_cur;
  logic [7:0] src;
  logic       lat;
  logic       two;
  logic       src_done;
  logic [1:0] last_pos;
  logic       final_byte;
  logic [7:0] obyte;

  assign load = !q_stat.empty && (!out_valid_r || !out_stall);

  always_comb begin
    at_cur = (pos_r == job.pend_cnt);
    case (pos_r)
      2'd0:    src = job.pend[0];
      2'd1:    src = job.pend[1];
      2'd2:    src = job.pend[2];
      default: src = job.cur_byte;
    endcase
    if (at_cur) begin
      src = job.cur_byte;
    end
    lat      = at_cur ? job.cur_lat : job.pend_lat;
    two      = lat && src[7];
    src_done = !two || half_r;
    // a job without the new byte always holds at least one byte
    last_pos = job.cur_en ? job.pend_cnt : job.pend_cnt - 2'd1;
    final_byte = src_done && (pos_r == last_pos);
    if (!two) begin
      obyte = src;
    end else if (!half_r) begin
      obyte = {6'b110000, src[7:6]};
    end else begin
      obyte = {2'b10, src[5:0]};
    end
  end

  assign q_pop     = load && final_byte;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 2'd0;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        if (final_byte) begin
          pos_r  <= 2'd0;
          half_r <= 1'b0;
        end else if (src_done) begin
          pos_r  <= pos_r + 2'd1;
          half_r <= 1'b0;
        end else begin
          half_r <= 1'b1;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.out_byte    <= obyte;
      out_data_r.run_last    <= final_byte;
      out_data_r.string_done <= final_byte && job.last;
    end
  end

endmodule

@@ hw/rtl/utf8_repair_latin1_fallback_unit.sv @@
// utf-8 repair with latin-1 fallback: input byte channel, output byte channel
// depends on u8r_pkg, u8r_front, u8r_queue, u8r_back
`timescale 1ns / 1ps

// usage:
//   in_valid/in_stall/in_data carry one raw byte per item plus the
//   end_of_string mark. out_valid/out_stall/out_data carry one repaired
//   byte per item; run_last marks the last byte caused by an input item and
//   string_done the last byte of a whole string.
//   cfg_wr_en/cfg_wr_data write repair_enable (reset value 1) while idle.
//   with the queue and output register free, the first output byte of an
//   item is registered in the job queue and then in the output register.
//   throughput: one input item per cycle while each item yields at most one
//   byte and out_stall is low; an item yielding n bytes (up to 8) holds the
//   back serializer, which emits one byte per cycle while out_stall is low.
//   Lead and mid-sequence bytes yield nothing and push no job to the back.
//   the job queue (QUEUE_DEPTH items) lets the front keep accepting while
//   the serializer expands a repair; in_stall rises only when it is full.
//   when out_stall is high the output byte holds and the serializer waits.
//   reset (rst_n low, synchronous) empties the queue and output register,
//   closes any open sequence and sets repair_enable to 1.
module utf8_repair_latin1_fallback_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  u8r_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output u8r_pkg::out_item_t out_data
);

  u8r_pkg::job_t    push_job;
  u8r_pkg::job_t    head_job;
  u8r_pkg::q_stat_t q_stat;
  logic             q_push;
  logic             q_pop;

  u8r_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_job       (push_job)
  );

  u8r_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  u8r_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (head_job),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.string_done) |-> out_data.run_last)
    else $error("string_done without run_last");

  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("job pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("job popped from empty queue");
`endif

endmodule
